// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic exec;
    logic load;
  } deq_cmd_t;

  typedef struct packed {
    logic need_read;
  } deq_stat_t;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 11;

endpackage

// ===== rtl/core/deq_ctrl.sv =====
module deq_ctrl import deq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  deq_stat_t stat_i,
  output deq_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.need_read ? S_LOAD : S_RESP;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/deq_dp.sv =====
module deq_dp import deq_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  deq_cmd_t                 cmd_i,
  output deq_stat_t                stat_o,
  input  logic [2:0]               operation_i,
  input  logic signed [WordW-1:0]  value_i,
  output logic signed [WordW-1:0]  popped_value_o,
  output logic [1:0]               status_o,
  output logic [CountW-1:0]        element_count_o,
  output logic                     is_empty_o,
  output logic signed [WordW-1:0]  front_value_o,
  output logic signed [WordW-1:0]  back_value_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = PW + 1;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  logic [WordW-1:0] store_mem [DEPTH];
  logic [WordW-1:0] rdata_q;

  logic [PW-1:0]    fp_q, fp_d, bp_q, bp_d;
  logic [CW-1:0]    count_q, count_d;
  logic [WordW-1:0] front_q, front_d, back_q, back_d;
  logic [WordW-1:0] popped_q, popped_d;
  status_e          status_q, status_d;
  logic             sel_front_q, sel_front_d;

  logic             empty, full;
  logic             wr_en, rd_en;
  logic [PW-1:0]    wr_addr, rd_addr;

  assign empty = (count_q == '0);
  assign full  = (count_q == CW'(DEPTH));

  always_comb begin
    fp_d        = fp_q;
    bp_d        = bp_q;
    count_d     = count_q;
    front_d     = front_q;
    back_d      = back_q;
    popped_d    = popped_q;
    status_d    = status_q;
    sel_front_d = sel_front_q;
    wr_en       = 1'b0;
    wr_addr     = fp_q;
    rd_en       = 1'b0;
    rd_addr     = fp_q;
    stat_o      = '0;
    if (cmd_i.exec) begin
      popped_d = '1;
      status_d = ST_OK;
      case (operation_i)
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            fp_d    = ptr_dec(fp_q);
            wr_en   = 1'b1;
            wr_addr = ptr_dec(fp_q);
            count_d = count_q + CW'(1);
            front_d = value_i;
            if (empty) begin
              back_d = value_i;
            end
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            bp_d    = ptr_inc(bp_q);
            wr_en   = 1'b1;
            wr_addr = bp_q;
            count_d = count_q + CW'(1);
            back_d  = value_i;
            if (empty) begin
              front_d = value_i;
            end
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            popped_d         = front_q;
            fp_d             = ptr_inc(fp_q);
            count_d          = count_q - CW'(1);
            rd_addr          = ptr_inc(fp_q);
            rd_en            = (count_q > CW'(1));
            sel_front_d      = 1'b1;
            stat_o.need_read = rd_en;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            popped_d         = back_q;
            bp_d             = ptr_dec(bp_q);
            count_d          = count_q - CW'(1);
            rd_addr          = ptr_dec(ptr_dec(bp_q));
            rd_en            = (count_q > CW'(1));
            sel_front_d      = 1'b0;
            stat_o.need_read = rd_en;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.load) begin
      if (sel_front_q) begin
        front_d = rdata_q;
      end else begin
        back_d = rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rdata_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q    <= '0;
      bp_q    <= '0;
      count_q <= '0;
    end else begin
      fp_q    <= fp_d;
      bp_q    <= bp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q     <= front_d;
    back_q      <= back_d;
    popped_q    <= popped_d;
    status_q    <= status_d;
    sel_front_q <= sel_front_d;
  end

  assign popped_value_o  = popped_q;
  assign status_o        = status_q;
  assign element_count_o = CountW'(count_q);
  assign is_empty_o      = empty;
  assign front_value_o   = empty ? '1 : front_q;
  assign back_value_o    = empty ? '1 : back_q;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fp_q} < CW'(DEPTH)) && ({1'b0, bp_q} < CW'(DEPTH)))
    else $error("pointer out of range");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && !full &&
    (operation_i == OP_PUSH_FRONT || operation_i == OP_PUSH_BACK)
    |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not advance occupancy");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && empty &&
    (operation_i == OP_POP_FRONT || operation_i == OP_POP_BACK)
    |=> status_q == ST_EMPTY && count_q == '0)
    else $error("pop on empty deque not flagged");

  a_read_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> $past(rd_en))
    else $error("load without a store read");
`endif

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries. Each input transaction pushes at the front or back, pops from the
// front or back, or only queries (operation codes 5 to 7 act as a query), and
// yields one output transaction with the popped word (-1 when none), a status
// (ok, pop on empty, push on full dropped), the count, an empty flag and the
// current front and back words (-1 when empty). The front and back words are
// kept in registers, so a transaction goes from acceptance in the idle state
// to the response state, where it waits until the output is taken; a pop that
// leaves one or more words passes through a load state between them, after one
// read of the store fetches the new end word. One transaction is in flight at a time.
module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               operation_i,
  input  logic signed [WordW-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [WordW-1:0]  popped_value_o,
  output logic [1:0]               status_o,
  output logic [CountW-1:0]        element_count_o,
  output logic                     is_empty_o,
  output logic signed [WordW-1:0]  front_value_o,
  output logic signed [WordW-1:0]  back_value_o
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .popped_value_o  (popped_value_o),
    .status_o        (status_o),
    .element_count_o (element_count_o),
    .is_empty_o      (is_empty_o),
    .front_value_o   (front_value_o),
    .back_value_o    (back_value_o)
  );

endmodule
